// ----- hw/rtl/rotation_matrix_to_zyz_euler_unit_defines.svh -----
// Assertion macros used by the port checker of the ZYZ Euler unit.
// No dependencies.
`ifndef ROTATION_MATRIX_TO_ZYZ_EULER_UNIT_DEFINES_SVH
`define ROTATION_MATRIX_TO_ZYZ_EULER_UNIT_DEFINES_SVH
`define RZE_ASSERT(label, clk, rst_n, prop, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) prop) else $error(msg);
`define RZE_ASSERT_NORST(label, clk, prop, msg) \
    label: assert property (@(posedge clk) prop) else $error(msg);
`endif

// ----- hw/rtl/rze_pkg.sv -----
// Package of the ZYZ Euler unit: widths, constants, angle table and case codes.
// No dependencies.
package rze_pkg;
    localparam int INPUT_FRAC_BITS   = 14;
    localparam int ANGLE_FRAC_BITS   = 13;
    localparam int CORDIC_ITERATIONS = 16;
    localparam int IN_W    = 16;
    localparam int ANG_W   = 16;
    localparam int BETA_W  = 15;
    localparam int CODE_W  = 2;
    localparam int INT_FRAC = 30;
    localparam int CW      = 34;
    localparam int ZW      = 34;
    localparam logic signed [ZW-1:0] PI_Q30      = 34'sd3373259426;
    localparam logic signed [ZW-1:0] HALF_PI_Q30 = 34'sd1686629713;

    typedef enum logic [CODE_W-1:0] {
        CASE_GENERAL = 2'd0,
        CASE_NEG_ONE = 2'd1,
        CASE_POS_ONE = 2'd2
    } t_case;

    function automatic logic signed [ZW-1:0] atan_q30(input int idx);
        logic signed [ZW-1:0] v;
        case (idx)
            0: v = 34'sd843314856;  1: v = 34'sd497837829;
            2: v = 34'sd263043836;  3: v = 34'sd133525158;
            4: v = 34'sd67021686;   5: v = 34'sd33543515;
            6: v = 34'sd16775850;   7: v = 34'sd8388437;
            8: v = 34'sd4194282;    9: v = 34'sd2097149;
            10: v = 34'sd1048575;   11: v = 34'sd524287;
            12: v = 34'sd262143;    13: v = 34'sd131071;
            14: v = 34'sd65535;     15: v = 34'sd32767;
            16: v = 34'sd16383;     17: v = 34'sd8191;
            18: v = 34'sd4095;      19: v = 34'sd2047;
            20: v = 34'sd1023;      21: v = 34'sd511;
            22: v = 34'sd255;       23: v = 34'sd127;
            24: v = 34'sd63;        25: v = 34'sd31;
            26: v = 34'sd15;        27: v = 34'sd8;
            28: v = 34'sd4;         29: v = 34'sd2;
            30: v = 34'sd1;
            default: v = '0;
        endcase
        return v;
    endfunction
endpackage

// ----- hw/rtl/rze_if.sv -----
// Valid/ready channel interfaces for the ZYZ Euler unit.
// Depends on rze_pkg.
interface rze_in_if;
    logic valid;
    logic ready;
    logic signed [rze_pkg::IN_W-1:0] m02, m10, m11, m12, m20, m21, m22;
    modport source (output valid, m02, m10, m11, m12, m20, m21, m22, input ready);
    modport sink (input valid, m02, m10, m11, m12, m20, m21, m22, output ready);
endinterface

interface rze_out_if;
    logic valid;
    logic ready;
    logic signed [rze_pkg::ANG_W-1:0] angle_alpha;
    logic [rze_pkg::BETA_W-1:0] angle_beta;
    logic signed [rze_pkg::ANG_W-1:0] angle_gamma;
    logic [rze_pkg::CODE_W-1:0] case_code;
    modport source (output valid, angle_alpha, angle_beta, angle_gamma, case_code,
        input ready);
    modport sink (input valid, angle_alpha, angle_beta, angle_gamma, case_code,
        output ready);
endinterface

// ----- hw/rtl/rze_sqrt.sv -----
// Pipelined integer square root of a Q(2F) value, one result bit per stage.
// Depends on rze_pkg.
module rze_sqrt #(
    parameter int IW = 2 * rze_pkg::INPUT_FRAC_BITS + 2,
    parameter int RW = rze_pkg::INPUT_FRAC_BITS + 1
) (
    input  logic          i_clk,
    input  logic          i_en,
    input  logic [IW-1:0] i_val,
    output logic [RW-1:0] o_root
);
    localparam int MW = RW + 2;

    logic [IW-1:0] r_val  [RW-1];
    logic [RW-1:0] r_rem  [RW-1];
    logic [RW-1:0] r_root [RW];

    for (genvar k = 0; k < RW; k++) begin : g_bit
        localparam int P = 2 * (RW - 1 - k);
        logic [IW-1:0] n_val_in;
        logic [RW-1:0] n_rem_in;
        logic [RW-1:0] n_root_in;
        logic [MW-1:0] n_acc;
        logic [MW-1:0] n_trial;
        logic          n_fit;
        if (k == 0) begin : g_first
            assign n_val_in  = i_val;
            assign n_rem_in  = '0;
            assign n_root_in = '0;
        end else begin : g_next
            assign n_val_in  = r_val[k-1];
            assign n_rem_in  = r_rem[k-1];
            assign n_root_in = r_root[k-1];
        end
        always_comb begin
            n_acc   = {n_rem_in, n_val_in[P+1 -: 2]};
            n_trial = {n_root_in, 2'b01};
            n_fit   = n_acc >= n_trial;
        end
        always_ff @(posedge i_clk) begin
            if (i_en) begin
                r_root[k] <= {n_root_in[RW-2:0], n_fit};
            end
        end
        if (k < RW - 1) begin : g_carry
            always_ff @(posedge i_clk) begin
                if (i_en) begin
                    r_val[k] <= n_val_in;
                    r_rem[k] <= n_fit ? RW'(n_acc - n_trial) : RW'(n_acc);
                end
            end
        end
    end

    assign o_root = r_root[RW-1];
endmodule

// ----- hw/rtl/rze_cordic.sv -----
// Vectoring CORDIC atan2 pipeline with normalization, quadrant fold and rounding.
// Depends on rze_pkg.
module rze_cordic #(
    parameter int ITER = rze_pkg::CORDIC_ITERATIONS,
    parameter int AFB  = rze_pkg::ANGLE_FRAC_BITS,
    parameter int DW   = 18
) (
    input  logic                            i_clk,
    input  logic                            i_en,
    input  logic signed [DW-1:0]            i_y,
    input  logic signed [DW-1:0]            i_x,
    output logic signed [rze_pkg::ANG_W-1:0] o_angle
);
    localparam int CW = rze_pkg::CW;
    localparam int ZW = rze_pkg::ZW;
    localparam int SH = rze_pkg::INT_FRAC - AFB;
    localparam int NLOG = $clog2(CW);

    // Stage 0: register inputs with normalization shift count.
    logic signed [CW-1:0] n_x0, n_y0;
    logic [CW-1:0] n_m;
    logic [NLOG-1:0] n_sh;
    logic n_zero;
    always_comb begin
        n_x0 = CW'(i_x);
        n_y0 = CW'(i_y);
        n_m  = (n_x0 < 0 ? -n_x0 : n_x0) | (n_y0 < 0 ? -n_y0 : n_y0);
        n_sh = '0;
        for (int b = 0; b < 30; b++) begin
            if (n_m[b]) n_sh = NLOG'(29 - b);
        end
        n_zero = (i_x == 0) && (i_y == 0);
    end
    // Max of magnitudes and OR share the top set bit, so the shift matches.

    logic signed [CW-1:0] r_x1, r_y1;
    logic [NLOG-1:0] r_sh1;
    logic r_z1;
    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r_x1 <= n_x0; r_y1 <= n_y0; r_sh1 <= n_sh; r_z1 <= n_zero;
        end
    end

    logic signed [CW-1:0] n_xs, n_ys, n_xp, n_yp;
    logic signed [ZW-1:0] n_zp;
    always_comb begin
        n_xs = r_x1 <<< r_sh1;
        n_ys = r_y1 <<< r_sh1;
        n_xp = n_xs; n_yp = n_ys; n_zp = '0;
        if (n_xs < 0) begin
            if (n_ys >= 0) begin
                n_xp = n_ys; n_yp = -n_xs; n_zp = rze_pkg::HALF_PI_Q30;
            end else begin
                n_xp = -n_ys; n_yp = n_xs; n_zp = -rze_pkg::HALF_PI_Q30;
            end
        end
    end

    logic signed [CW-1:0] r_x [ITER+1];
    logic signed [CW-1:0] r_y [ITER+1];
    logic signed [ZW-1:0] r_z [ITER+1];
    logic r_zr [ITER+1];
    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r_x[0] <= n_xp; r_y[0] <= n_yp; r_z[0] <= n_zp; r_zr[0] <= r_z1;
        end
    end

    for (genvar i = 0; i < ITER; i++) begin : g_it
        localparam int S = i % 32;
        always_ff @(posedge i_clk) begin
            if (i_en) begin
                r_zr[i+1] <= r_zr[i];
                if (r_y[i] >= 0) begin
                    r_x[i+1] <= r_x[i] + (r_y[i] >>> S);
                    r_y[i+1] <= r_y[i] - (r_x[i] >>> S);
                    r_z[i+1] <= r_z[i] + rze_pkg::atan_q30(S);
                end else begin
                    r_x[i+1] <= r_x[i] - (r_y[i] >>> S);
                    r_y[i+1] <= r_y[i] + (r_x[i] >>> S);
                    r_z[i+1] <= r_z[i] - rze_pkg::atan_q30(S);
                end
            end
        end
    end

    localparam logic signed [ZW-1:0] PI_OUT =
        (rze_pkg::PI_Q30 + (ZW'(1) <<< (SH - 1))) >>> SH;
    logic signed [ZW-1:0] n_r;
    logic signed [rze_pkg::ANG_W-1:0] r_out;
    always_comb begin
        n_r = r_zr[ITER] ? '0 : r_z[ITER];
        n_r = (n_r + (ZW'(1) <<< (SH - 1))) >>> SH;
        if (n_r > PI_OUT) n_r = PI_OUT;
        if (n_r < -PI_OUT) n_r = -PI_OUT;
    end
    always_ff @(posedge i_clk) begin
        if (i_en) r_out <= rze_pkg::ANG_W'(n_r);
    end
    assign o_angle = r_out;
endmodule

// ----- hw/rtl/rotation_matrix_to_zyz_euler_unit.sv -----
// ZYZ Euler angles from a rotation matrix. Fully pipelined: one matrix per cycle
// while the pipe is not stalled. The stages are an input register, a stage that
// classifies m22 and forms 1 - m22^2, one stage per root bit of the square root,
// then per CORDIC a normalization stage, a fold stage, one stage per iteration
// and a rounding stage.
// A global enable stalls the whole pipe while the output holds an untaken transaction.
module rotation_matrix_to_zyz_euler_unit #(
    parameter int CORDIC_ITERATIONS = rze_pkg::CORDIC_ITERATIONS
) (
    input logic i_clk,
    input logic i_rst_n,
    rze_in_if.sink    i_in,
    rze_out_if.source o_out
);
    localparam int F   = rze_pkg::INPUT_FRAC_BITS;
    localparam int SQ  = F + 1;
    localparam int LAT = CORDIC_ITERATIONS + SQ + 4;
    localparam int DW  = 18;
    localparam int PW  = 2 * rze_pkg::IN_W;
    localparam int OPW = 5 * DW;

    logic n_en;
    logic [LAT:0] r_vld;
    assign n_en = !r_vld[LAT] || o_out.ready;
    assign i_in.ready = n_en;

    // Stage A: register the matrix entries and classify m22.
    logic signed [rze_pkg::IN_W-1:0] r_m02, r_m10, r_m11, r_m12, r_m20, r_m21, r_m22;
    always_ff @(posedge i_clk) begin
        if (n_en) begin
            r_m02 <= i_in.m02; r_m10 <= i_in.m10; r_m11 <= i_in.m11;
            r_m12 <= i_in.m12; r_m20 <= i_in.m20; r_m21 <= i_in.m21;
            r_m22 <= i_in.m22;
        end
    end
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) r_vld <= '0;
        else if (n_en) r_vld <= {r_vld[LAT-1:0], i_in.valid};
    end

    localparam logic signed [DW-1:0] ONE = DW'(1) <<< F;
    localparam logic signed [PW-1:0] ONE_SQ = PW'(1) <<< (2 * F);
    rze_pkg::t_case n_case;
    always_comb begin
        if (DW'(r_m22) >= ONE) n_case = rze_pkg::CASE_POS_ONE;
        else if (DW'(r_m22) <= -ONE) n_case = rze_pkg::CASE_NEG_ONE;
        else n_case = rze_pkg::CASE_GENERAL;
    end

    logic [2*F+1:0] n_rem;
    logic signed [PW-1:0] n_sq;
    always_comb begin
        n_sq  = PW'(r_m22) * PW'(r_m22);
        n_rem = (2*F+2)'(ONE_SQ - n_sq);
    end

    // Stage B: CORDIC operands and the radicand.
    logic [2*F+1:0] r_rem;
    logic signed [DW-1:0] r_ay, r_ax, r_gy, r_gx, r_bx;
    rze_pkg::t_case r_case [LAT];
    always_ff @(posedge i_clk) begin
        if (n_en) begin
            if (n_case == rze_pkg::CASE_GENERAL) begin
                r_ay <= DW'(r_m12); r_ax <= DW'(r_m02);
            end else begin
                r_ay <= DW'(r_m10); r_ax <= DW'(r_m11);
            end
            r_gy <= DW'(r_m21); r_gx <= -DW'(r_m20); r_bx <= DW'(r_m22);
            r_rem <= n_rem;
            r_case[0] <= n_case;
            for (int k = 1; k < LAT; k++) r_case[k] <= r_case[k-1];
        end
    end

    // The operands wait beside the square root pipeline.
    logic [F:0] w_sn;
    rze_sqrt #(.IW(2*F+2), .RW(SQ)) u_sqrt (
        .i_clk(i_clk), .i_en(n_en), .i_val(r_rem), .o_root(w_sn));

    logic [OPW-1:0] r_ops [SQ];
    always_ff @(posedge i_clk) begin
        if (n_en) begin
            r_ops[0] <= {r_ay, r_ax, r_gy, r_gx, r_bx};
            for (int k = 1; k < SQ; k++) r_ops[k] <= r_ops[k-1];
        end
    end

    logic signed [DW-1:0] w_ay, w_ax, w_gy, w_gx, w_bx;
    assign {w_ay, w_ax, w_gy, w_gx, w_bx} = r_ops[SQ-1];

    logic signed [rze_pkg::ANG_W-1:0] w_a, w_b, w_g;
    rze_cordic #(.ITER(CORDIC_ITERATIONS), .DW(DW)) u_ca (.i_clk(i_clk), .i_en(n_en),
        .i_y(w_ay), .i_x(w_ax), .o_angle(w_a));
    rze_cordic #(.ITER(CORDIC_ITERATIONS), .DW(DW)) u_cb (.i_clk(i_clk), .i_en(n_en),
        .i_y(DW'(w_sn)), .i_x(w_bx), .o_angle(w_b));
    rze_cordic #(.ITER(CORDIC_ITERATIONS), .DW(DW)) u_cg (.i_clk(i_clk), .i_en(n_en),
        .i_y(w_gy), .i_x(w_gx), .o_angle(w_g));

    rze_pkg::t_case w_c;
    assign w_c = r_case[LAT-1];
    always_comb begin
        o_out.valid = r_vld[LAT];
        o_out.case_code = w_c;
        unique case (w_c)
            rze_pkg::CASE_POS_ONE: begin
                o_out.angle_alpha = w_a; o_out.angle_beta = '0; o_out.angle_gamma = '0;
            end
            rze_pkg::CASE_NEG_ONE: begin
                o_out.angle_alpha = -w_a;
                o_out.angle_beta = rze_pkg::BETA_W'(25736);
                o_out.angle_gamma = '0;
            end
            default: begin
                o_out.angle_alpha = w_a;
                o_out.angle_beta = w_b[rze_pkg::ANG_W-1] ? '0 : rze_pkg::BETA_W'(w_b);
                o_out.angle_gamma = w_g;
            end
        endcase
    end
endmodule

// ----- hw/rtl/rze_checker.sv -----
// Port checker for the ZYZ Euler unit, bound to the top level.
// Depends on rze_pkg and the defines header.
`include "rotation_matrix_to_zyz_euler_unit_defines.svh"
module rze_checker (
    input logic i_clk,
    input logic i_rst_n,
    input logic in_ready, out_valid, out_ready,
    input logic [rze_pkg::CODE_W-1:0] case_code,
    input logic [rze_pkg::BETA_W-1:0] angle_beta
);
    `RZE_ASSERT(a_code, i_clk, i_rst_n, out_valid |-> case_code <= rze_pkg::CASE_POS_ONE, "bad case code")
    `RZE_ASSERT(a_beta, i_clk, i_rst_n, out_valid |-> angle_beta <= 15'd25736, "beta range")
    `RZE_ASSERT(a_hold, i_clk, i_rst_n, out_valid && !out_ready |=> out_valid, "drop")
    `RZE_ASSERT(a_ready, i_clk, i_rst_n, !out_valid |-> in_ready, "input blocked while empty")
    `RZE_ASSERT_NORST(a_rst, i_clk, !i_rst_n |=> !out_valid, "valid after reset")
endmodule

bind rotation_matrix_to_zyz_euler_unit rze_checker u_chk (
    .i_clk(i_clk), .i_rst_n(i_rst_n), .in_ready(i_in.ready),
    .out_valid(o_out.valid), .out_ready(o_out.ready), .case_code(o_out.case_code),
    .angle_beta(o_out.angle_beta));

// ----- verif/tb_rotation_matrix_to_zyz_euler_unit.sv -----
// Self-checking testbench of the ZYZ Euler unit: directed table, then random matrices.
// Results are predicted by a CORDIC model of its own. Depends on rze_pkg and rze_if.
module tb_rotation_matrix_to_zyz_euler_unit;
    localparam int NUM_RANDOM = 1700;
    localparam int WATCHDOG_LIMIT = 20000;
    localparam int DRAIN_CYCLES = rze_pkg::CORDIC_ITERATIONS + rze_pkg::INPUT_FRAC_BITS + 40;
    localparam logic signed [15:0] ONE = 16'sd16384;

    typedef struct packed {
        logic signed [15:0] m02, m10, m11, m12, m20, m21, m22;
    } t_matrix;

    typedef struct packed {
        logic signed [15:0] alpha;
        logic [14:0] beta;
        logic signed [15:0] gamma;
        rze_pkg::t_case code;
    } t_angles;

    typedef struct {
        t_matrix mat;
        bit has_fixed;
        t_angles fixed;
    } t_row;

    logic i_clk;
    logic i_rst_n;
    rze_in_if in_ch();
    rze_out_if out_ch();

    t_angles angles_pending[$];
    int error_count;
    int idle_cycles = 0;
    int rx_idle_left = 0;
    bit stimulus_done;
    bit no_idling;
    bit hold_off;

    rotation_matrix_to_zyz_euler_unit DUT (
        .i_clk(i_clk),
        .i_rst_n(i_rst_n),
        .i_in(in_ch.sink),
        .o_out(out_ch.source)
    );

    initial i_clk = 1'b0;
    always #5 i_clk = ~i_clk;

    function automatic longint shift_down(longint v, int s);
        return v >>> s;
    endfunction

    function automatic longint vector_angle(longint y, longint x);
        longint z, t, ax, ay, mx, xs, ys;
        z = 0;
        if (x == 0 && y == 0) return 0;
        ax = x < 0 ? -x : x;
        ay = y < 0 ? -y : y;
        mx = ax > ay ? ax : ay;
        while (mx < (64'sd1 << 29)) begin
            x = x * 2;
            y = y * 2;
            mx = mx * 2;
        end
        if (x < 0) begin
            t = x;
            if (y >= 0) begin
                x = y; y = -t; z = rze_pkg::HALF_PI_Q30;
            end else begin
                x = -y; y = t; z = -rze_pkg::HALF_PI_Q30;
            end
        end
        for (int i = 0; i < rze_pkg::CORDIC_ITERATIONS; i++) begin
            xs = shift_down(x, i % 32);
            ys = shift_down(y, i % 32);
            if (y >= 0) begin
                x = x + ys; y = y - xs; z = z + longint'(rze_pkg::atan_q30(i % 32));
            end else begin
                x = x - ys; y = y + xs; z = z - longint'(rze_pkg::atan_q30(i % 32));
            end
        end
        return z;
    endfunction

    function automatic longint pi_rounded();
        int s;
        s = rze_pkg::INT_FRAC - rze_pkg::ANGLE_FRAC_BITS;
        return shift_down(longint'(rze_pkg::PI_Q30) + (64'sd1 << (s - 1)), s);
    endfunction

    function automatic longint round_angle(longint z);
        int s;
        longint r, p;
        s = rze_pkg::INT_FRAC - rze_pkg::ANGLE_FRAC_BITS;
        r = shift_down(z + (64'sd1 << (s - 1)), s);
        p = pi_rounded();
        if (r > p) r = p;
        if (r < -p) r = -p;
        return r;
    endfunction

    function automatic longint floor_sqrt(longint v);
        longint r;
        r = 0;
        while ((r + 1) * (r + 1) <= v) r = r + 1;
        return r;
    endfunction

    function automatic t_angles euler_angles(t_matrix m);
        t_angles a;
        longint sn, al, be, ga;
        if (m.m22 >= ONE) begin
            al = round_angle(vector_angle(m.m10, m.m11));
            be = 0; ga = 0; a.code = rze_pkg::CASE_POS_ONE;
        end else if (m.m22 <= -ONE) begin
            al = -round_angle(vector_angle(m.m10, m.m11));
            be = pi_rounded(); ga = 0; a.code = rze_pkg::CASE_NEG_ONE;
        end else begin
            sn = floor_sqrt(longint'(ONE) * ONE - longint'(m.m22) * m.m22);
            al = round_angle(vector_angle(m.m12, m.m02));
            be = round_angle(vector_angle(sn, m.m22));
            if (be < 0) be = 0;
            ga = round_angle(vector_angle(m.m21, -longint'(m.m20)));
            a.code = rze_pkg::CASE_GENERAL;
        end
        a.alpha = al[15:0];
        a.beta = be[14:0];
        a.gamma = ga[15:0];
        return a;
    endfunction

    function automatic t_matrix make_matrix(int a, int b, int c, int d, int e, int f, int g);
        t_matrix m;
        m.m02 = 16'(a); m.m10 = 16'(b); m.m11 = 16'(c); m.m12 = 16'(d);
        m.m20 = 16'(e); m.m21 = 16'(f); m.m22 = 16'(g);
        return m;
    endfunction

    function automatic t_angles make_angles(int a, int b, int g, rze_pkg::t_case c);
        t_angles r;
        r.alpha = 16'(a); r.beta = 15'(b); r.gamma = 16'(g); r.code = c;
        return r;
    endfunction

    function automatic logic signed [15:0] entry_value();
        case ($urandom_range(0, 5))
            0: return 16'($urandom);
            1: return $urandom_range(0, 1) ? ONE : -ONE;
            2: return 16'($urandom_range(0, 4)) - 16'sd2;
            default: return 16'(int'($urandom_range(0, 32768)) - 16384);
        endcase
    endfunction

    function automatic t_matrix random_matrix();
        t_matrix m;
        m.m02 = entry_value(); m.m10 = entry_value(); m.m11 = entry_value();
        m.m12 = entry_value(); m.m20 = entry_value(); m.m21 = entry_value();
        case ($urandom_range(0, 7))
            0: m.m22 = ONE;
            1: m.m22 = -ONE;
            2: m.m22 = 16'($urandom);
            3: m.m22 = $urandom_range(0, 1) ? ONE - 16'sd1 : -ONE + 16'sd1;
            default: m.m22 = 16'(int'($urandom_range(0, 32766)) - 16383);
        endcase
        return m;
    endfunction

    task automatic report_mismatch(string what, int got, int want);
        $display("mismatch in %s: got %0d, expected %0d", what, got, want);
        error_count++;
    endtask

    task automatic send_matrix(t_matrix m, bit has_fixed, t_angles fixed);
        t_angles want;
        if (!no_idling && $urandom_range(0, 9) == 0) begin
            in_ch.valid <= 1'b0;
            repeat ($urandom_range(1, 18)) @(posedge i_clk);
        end
        in_ch.valid <= 1'b1;
        in_ch.m02 <= m.m02; in_ch.m10 <= m.m10; in_ch.m11 <= m.m11;
        in_ch.m12 <= m.m12; in_ch.m20 <= m.m20; in_ch.m21 <= m.m21;
        in_ch.m22 <= m.m22;
        do @(posedge i_clk); while (!in_ch.ready);
        want = euler_angles(m);
        if (has_fixed && want != fixed) begin
            report_mismatch("table row", int'(want.alpha), int'(fixed.alpha));
            want = fixed;
        end
        angles_pending.push_back(want);
    endtask

    initial begin
        t_row rows[$];
        t_row r;
        t_angles none;
        i_rst_n = 1'b0;
        in_ch.valid = 1'b0;
        in_ch.m02 = '0; in_ch.m10 = '0; in_ch.m11 = '0; in_ch.m12 = '0;
        in_ch.m20 = '0; in_ch.m21 = '0; in_ch.m22 = '0;
        error_count = 0;
        stimulus_done = 0;
        no_idling = 0;
        none = make_angles(0, 0, 0, rze_pkg::CASE_GENERAL);
        r.has_fixed = 1;
        r.mat = make_matrix(0, 0, 0, 0, 0, 0, 16384);
        r.fixed = make_angles(0, 0, 0, rze_pkg::CASE_POS_ONE); rows.push_back(r);
        r.mat = make_matrix(0, 0, 0, 0, 0, 0, -16384);
        r.fixed = make_angles(0, 25736, 0, rze_pkg::CASE_NEG_ONE); rows.push_back(r);
        r.mat = make_matrix(0, 0, 16384, 0, 0, 0, 32767);
        r.fixed = make_angles(0, 0, 0, rze_pkg::CASE_POS_ONE); rows.push_back(r);
        r.mat = make_matrix(0, 0, 16384, 0, 0, 0, -32768);
        r.fixed = make_angles(0, 25736, 0, rze_pkg::CASE_NEG_ONE); rows.push_back(r);
        r.mat = make_matrix(0, 0, 0, 0, 0, 0, 0);
        r.fixed = make_angles(0, 12868, 0, rze_pkg::CASE_GENERAL); rows.push_back(r);
        r.has_fixed = 0;
        r.mat = make_matrix(-16384, 0, -16384, 0, 16384, 0, 0); rows.push_back(r);
        r.mat = make_matrix(-16384, 0, -16384, -1, 16384, -1, 0); rows.push_back(r);
        r.mat = make_matrix(16384, 16384, 0, 16384, -16384, 16384, 16383); rows.push_back(r);
        r.mat = make_matrix(-32768, 32767, -32768, 32767, -32768, 32767, -16383);
        rows.push_back(r);
        r.mat = make_matrix(32767, -32768, 32767, -32768, 32767, -32768, 1); rows.push_back(r);
        r.mat = make_matrix(1, -1, -1, 1, 1, -1, -1); rows.push_back(r);
        r.mat = make_matrix(0, 16384, -16384, 0, 0, 0, 16384); rows.push_back(r);
        r.mat = make_matrix(0, -16384, -16384, 0, 0, 0, -16384); rows.push_back(r);
        r.mat = make_matrix(11585, 11585, 11585, 11585, 11585, 11585, 11585); rows.push_back(r);
        repeat (4) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);
        foreach (rows[i]) send_matrix(rows[i].mat, rows[i].has_fixed, rows[i].fixed);
        for (int n = 0; n < NUM_RANDOM; n++) begin
            if (n == NUM_RANDOM - 200) no_idling = 1;
            send_matrix(random_matrix(), 0, none);
        end
        in_ch.valid <= 1'b0;
        stimulus_done = 1;
    end

    // The long hold-off is timed here; the receiver below only follows the flag.
    initial begin
        @(posedge i_rst_n);
        repeat (60) @(posedge i_clk);
        hold_off <= 1'b1;
        repeat (80) @(posedge i_clk);
        hold_off <= 1'b0;
    end

    initial out_ch.ready = 1'b0;

    always @(posedge i_clk) begin
        if (!i_rst_n || hold_off) begin
            out_ch.ready <= 1'b0;
        end else if (rx_idle_left > 0) begin
            rx_idle_left <= rx_idle_left - 1;
            out_ch.ready <= 1'b0;
        end else if (!no_idling && $urandom_range(0, 15) == 0) begin
            rx_idle_left <= int'($urandom_range(1, 18)) - 1;
            out_ch.ready <= 1'b0;
        end else begin
            out_ch.ready <= 1'b1;
        end
    end

    always @(posedge i_clk) begin
        t_angles want;
        if (i_rst_n && out_ch.valid && out_ch.ready) begin
            if (angles_pending.size() == 0) begin
                report_mismatch("extra result", 1, 0);
            end else begin
                want = angles_pending.pop_front();
                if (out_ch.angle_alpha !== want.alpha)
                    report_mismatch("alpha", out_ch.angle_alpha, want.alpha);
                if (out_ch.angle_beta !== want.beta)
                    report_mismatch("beta", out_ch.angle_beta, want.beta);
                if (out_ch.angle_gamma !== want.gamma)
                    report_mismatch("gamma", out_ch.angle_gamma, want.gamma);
                if (out_ch.case_code !== want.code)
                    report_mismatch("case", out_ch.case_code, want.code);
            end
        end
    end

    always @(posedge i_clk) begin
        if ((in_ch.valid && in_ch.ready) || (out_ch.valid && out_ch.ready))
            idle_cycles <= 0;
        else
            idle_cycles <= idle_cycles + 1;
    end

    initial begin
        @(posedge i_rst_n);
        while (!(stimulus_done && angles_pending.size() == 0)
               && idle_cycles < WATCHDOG_LIMIT)
            @(posedge i_clk);
        if (idle_cycles >= WATCHDOG_LIMIT) begin
            $display("tb_rotation_matrix_to_zyz_euler_unit: errors");
        end else begin
            repeat (DRAIN_CYCLES) @(posedge i_clk);
            if (error_count == 0 && angles_pending.size() == 0)
                $display("tb_rotation_matrix_to_zyz_euler_unit: clean");
            else
                $display("tb_rotation_matrix_to_zyz_euler_unit: errors");
        end
        $finish;
    end
endmodule
